@@ rtl/nearest_atom_density_projection_unit_defines.svh @@
// ----------------------------------------------------------------------------
// nearest_atom_density_projection_unit_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef NEAREST_ATOM_DENSITY_PROJECTION_UNIT_DEFINES_SVH
`define NEAREST_ATOM_DENSITY_PROJECTION_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NADP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nadp check failed");

// next-cycle implication, disabled during reset
`define NADP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nadp check failed");

`endif

@@ rtl/nadp_pkg.sv @@
// ----------------------------------------------------------------------------
// nadp_pkg
// Types, constants and codes of the nearest atom density projection unit.
// ----------------------------------------------------------------------------
package nadp_pkg;

   // table capacity and derived widths
   localparam int MAX_ATOMS = 64;
   localparam int ADDR_W    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int LOAD_W    = $clog2(MAX_ATOMS + 1);
   localparam int ACC_BITS  = 48;

   // field widths
   localparam int POS_W   = 24;
   localparam int DENS_W  = 32;
   localparam int NUC_W   = 16;
   localparam int OUT_W   = 48;
   localparam int CNT_W   = 24;
   localparam int CUT_W   = 48;
   localparam int VOL_W   = 32;
   localparam int DIST_W  = 50;
   localparam int MAG_W   = 51;

   // arithmetic constants
   localparam logic [31:0]      SQRT2_Q30 = 32'd1518500250;
   localparam logic [63:0]      MID_CAP   = 64'd1 << 50;
   localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

   // input item kinds
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // result kinds
   localparam logic RES_SAMPLE = 1'b0;
   localparam logic RES_TOTAL  = 1'b1;

   // register indexes
   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_VOLUME = 2'd1;
   localparam logic [1:0] REG_CUTOFF = 2'd2;

   // register reset values
   localparam logic [VOL_W-1:0] VOLUME_RST = 32'd16777216;
   localparam logic [CUT_W-1:0] CUTOFF_RST = 48'd1677721600;

   typedef struct packed {
      logic [1:0]              kind;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [DENS_W-1:0] density;
      logic [NUC_W-1:0]        nuclear_charge;
   } req_type;

   typedef struct packed {
      logic                    result_kind;
      logic [5:0]              atom_index;
      logic                    found;
      logic signed [OUT_W-1:0] projected_charge;
      logic [CNT_W-1:0]        element_count;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic             density_mode;
      logic [VOL_W-1:0] voxel_volume;
      logic [CUT_W-1:0] cutoff_sq;
   } cfg_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [NUC_W-1:0]        q;
   } atom_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] sum;
      logic [CNT_W-1:0]           cnt;
   } acc_type;

   // controller to datapath
   typedef struct packed {
      logic              capture;
      logic              load_atom;
      logic              scan_start;
      logic              scan_issue;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              acc_rd;
      logic              acc_use_best;
      logic              acc_wr;
      logic              proj_init;
      logic              mul_en;
      logic              mul_hi;
      logic              mul_comb;
      logic              mul_step;
      logic              out_sample;
      logic              out_total;
      logic              out_last;
      logic              clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [LOAD_W-1:0] atoms_loaded;
      logic              hit;
      logic              out_free;
      logic              mode;
   } status_type;

endpackage

@@ rtl/nadp_csr.sv @@
// ----------------------------------------------------------------------------
// nadp_csr
// Configuration registers behind the register port.
// ----------------------------------------------------------------------------
module nadp_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [63:0]         pwdata,
   output logic [63:0]         prdata,
   output logic                pready,
   output nadp_pkg::cfg_type   cfg
);

   logic                         mode_ff;
   logic [nadp_pkg::VOL_W-1:0]   vol_ff;
   logic [nadp_pkg::CUT_W-1:0]   cut_ff;
   logic                         wr_en;

   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         vol_ff  <= nadp_pkg::VOLUME_RST;
         cut_ff  <= nadp_pkg::CUTOFF_RST;
      end else if (wr_en) begin
         unique case (paddr[4:3])
            nadp_pkg::REG_MODE:   mode_ff <= pwdata[0];
            nadp_pkg::REG_VOLUME: vol_ff  <= pwdata[nadp_pkg::VOL_W-1:0];
            nadp_pkg::REG_CUTOFF: cut_ff  <= pwdata[nadp_pkg::CUT_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (paddr[4:3])
         nadp_pkg::REG_MODE:   prdata = {63'd0, mode_ff};
         nadp_pkg::REG_VOLUME: prdata = {32'd0, vol_ff};
         nadp_pkg::REG_CUTOFF: prdata = {16'd0, cut_ff};
         default:              prdata = 64'd0;
      endcase
   end

   assign cfg.density_mode = mode_ff;
   assign cfg.voxel_volume = vol_ff;
   assign cfg.cutoff_sq    = cut_ff;

endmodule

@@ rtl/nadp_ctrl.sv @@
// ----------------------------------------------------------------------------
// nadp_ctrl
// Sequencer: atom scan, accumulator update, projection steps and emission.
// ----------------------------------------------------------------------------
module nadp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_kind,
   output logic                   req_stall,
   input  nadp_pkg::status_type   status,
   output nadp_pkg::cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_DRAIN, ST_ACC_RD, ST_ACC_WR, ST_SMP_OUT,
      ST_FIN_RD, ST_FIN_INIT, ST_MUL_LO, ST_MUL_HI, ST_MUL_COMB, ST_FIN_OUT
   } state_type;

   state_type                      state_ff, state_in;
   logic [nadp_pkg::LOAD_W-1:0]    idx_ff, idx_in;
   logic [1:0]                     drain_ff, drain_in;
   logic                           step_ff, step_in;
   logic                           accept;
   logic                           is_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign is_last   = (idx_ff == status.atoms_loaded - nadp_pkg::LOAD_W'(1));

   // next state and commands
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      drain_in = drain_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.rd_addr  = idx_ff[nadp_pkg::ADDR_W-1:0];
      cmd.mul_step = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  nadp_pkg::KIND_LOAD: cmd.load_atom = 1'b1;
                  nadp_pkg::KIND_SAMPLE: begin
                     cmd.capture    = 1'b1;
                     cmd.scan_start = 1'b1;
                     idx_in         = '0;
                     state_in = (status.atoms_loaded == '0) ? ST_SMP_OUT : ST_SCAN;
                  end
                  nadp_pkg::KIND_FINISH: begin
                     idx_in = '0;
                     if (status.atoms_loaded == '0) cmd.clear = 1'b1;
                     else                           state_in = ST_FIN_RD;
                  end
                  default: ;
               endcase
            end
         end
         // one atom issued per cycle
         ST_SCAN: begin
            cmd.rd_en      = 1'b1;
            cmd.scan_issue = 1'b1;
            idx_in         = idx_ff + nadp_pkg::LOAD_W'(1);
            if (is_last) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         // wait for the compare stage to see the last atom
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd2) state_in = ST_ACC_RD;
         end
         ST_ACC_RD: begin
            if (status.hit) begin
               cmd.acc_rd       = 1'b1;
               cmd.acc_use_best = 1'b1;
               state_in         = ST_ACC_WR;
            end else begin
               state_in = ST_SMP_OUT;
            end
         end
         ST_ACC_WR: begin
            cmd.acc_wr = 1'b1;
            state_in   = ST_SMP_OUT;
         end
         ST_SMP_OUT: begin
            if (status.out_free) begin
               cmd.out_sample = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_FIN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.acc_rd = 1'b1;
            state_in   = ST_FIN_INIT;
         end
         ST_FIN_INIT: begin
            cmd.proj_init = 1'b1;
            step_in       = 1'b0;
            state_in      = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_en = 1'b1;
            cmd.mul_hi = 1'b1;
            state_in   = ST_MUL_COMB;
         end
         // second pass by sqrt(2) in transition mode
         ST_MUL_COMB: begin
            cmd.mul_comb = 1'b1;
            if (!step_ff && status.mode) begin
               step_in  = 1'b1;
               state_in = ST_MUL_LO;
            end else begin
               state_in = ST_FIN_OUT;
            end
         end
         ST_FIN_OUT: begin
            if (status.out_free) begin
               cmd.out_total = 1'b1;
               cmd.out_last  = is_last;
               if (is_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + nadp_pkg::LOAD_W'(1);
                  state_in = ST_FIN_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         drain_ff <= '0;
         step_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         drain_ff <= drain_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ rtl/nadp_dpath.sv @@
// ----------------------------------------------------------------------------
// nadp_dpath
// Atom table, distance pipeline, accumulators, projection multiplier and
// result register.
// ----------------------------------------------------------------------------
module nadp_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  nadp_pkg::req_type      req_payload,
   input  nadp_pkg::cfg_type      cfg,
   input  nadp_pkg::cmd_type      cmd,
   output nadp_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output nadp_pkg::rsp_type      rsp_payload
);

   localparam int AW = nadp_pkg::ADDR_W;
   localparam int PW = nadp_pkg::POS_W;

   // memories
   nadp_pkg::atom_type atom_mem [nadp_pkg::MAX_ATOMS];
   nadp_pkg::acc_type  acc_mem  [nadp_pkg::MAX_ATOMS];
   logic [nadp_pkg::MAX_ATOMS-1:0] acc_vld_ff;

   logic [nadp_pkg::LOAD_W-1:0]   loaded_ff;
   logic signed [PW-1:0]          sx_ff, sy_ff, sz_ff;
   logic signed [nadp_pkg::DENS_W-1:0] dens_ff;

   // scan pipeline
   nadp_pkg::atom_type            atom_rd_ff;
   logic                          v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]                 idx1_ff, idx2_ff, idx3_ff;
   logic signed [PW:0]            dx_ff, dy_ff, dz_ff;
   logic signed [2*PW+1:0]        sqx, sqy, sqz;
   logic [2*PW-1:0]               qx_ff, qy_ff, qz_ff;
   logic [nadp_pkg::DIST_W-1:0]   d2;
   logic [nadp_pkg::DIST_W-1:0]   best_ff;
   logic [AW-1:0]                 best_idx_ff;
   logic                          hit_ff;

   // accumulator access
   logic [AW-1:0]                 acc_addr;
   logic [AW-1:0]                 acc_addr_ff;
   nadp_pkg::acc_type             acc_rd_ff;
   logic                          acc_rd_vld_ff;
   nadp_pkg::acc_type             acc_cur;
   nadp_pkg::acc_type             acc_new;
   logic signed [nadp_pkg::ACC_BITS:0] sum_wide;
   logic [nadp_pkg::CNT_W-1:0]    res_cnt_ff;

   // projection
   logic                          neg_ff;
   logic [nadp_pkg::MAG_W-1:0]    mag_ff;
   logic [31:0]                   mul_a, mul_b;
   logic [63:0]                   prod;
   logic [63:0]                   p_ff, q_ff;
   logic [64:0]                   rnd;
   logic [63:0]                   rsh, qsh, lim, tsum, tcap;
   logic signed [52:0]            sval, vfin;
   logic signed [nadp_pkg::OUT_W-1:0] vsat;

   // output register
   logic                          rsp_valid_ff;
   nadp_pkg::rsp_type             rsp_ff;
   logic                          out_free;

   // item capture, load counter, valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff  <= '0;
         acc_vld_ff <= '0;
      end else if (cmd.clear) begin
         loaded_ff  <= '0;
         acc_vld_ff <= '0;
      end else begin
         if (cmd.load_atom && loaded_ff != nadp_pkg::LOAD_W'(nadp_pkg::MAX_ATOMS))
            loaded_ff <= loaded_ff + nadp_pkg::LOAD_W'(1);
         if (cmd.acc_wr) acc_vld_ff[acc_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sx_ff   <= req_payload.pos_x;
         sy_ff   <= req_payload.pos_y;
         sz_ff   <= req_payload.pos_z;
         dens_ff <= req_payload.density;
      end
   end

   // atom table
   always_ff @(posedge clock) begin
      if (cmd.load_atom && loaded_ff != nadp_pkg::LOAD_W'(nadp_pkg::MAX_ATOMS))
         atom_mem[loaded_ff[AW-1:0]] <= '{x: req_payload.pos_x, y: req_payload.pos_y,
                                          z: req_payload.pos_z,
                                          q: req_payload.nuclear_charge};
      if (cmd.rd_en) atom_rd_ff <= atom_mem[cmd.rd_addr];
   end

   // distance pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.scan_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign sqx = dx_ff * dx_ff;
   assign sqy = dy_ff * dy_ff;
   assign sqz = dz_ff * dz_ff;
   assign d2  = nadp_pkg::DIST_W'(qx_ff) + nadp_pkg::DIST_W'(qy_ff)
              + nadp_pkg::DIST_W'(qz_ff);

   // differences, squares, compare
   always_ff @(posedge clock) begin
      idx1_ff <= cmd.rd_addr;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      dx_ff   <= {atom_rd_ff.x[PW-1], atom_rd_ff.x} - {sx_ff[PW-1], sx_ff};
      dy_ff   <= {atom_rd_ff.y[PW-1], atom_rd_ff.y} - {sy_ff[PW-1], sy_ff};
      dz_ff   <= {atom_rd_ff.z[PW-1], atom_rd_ff.z} - {sz_ff[PW-1], sz_ff};
      qx_ff   <= sqx[2*PW-1:0];
      qy_ff   <= sqy[2*PW-1:0];
      qz_ff   <= sqz[2*PW-1:0];
   end

   // running minimum, strictly below so ties keep the lower index
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         hit_ff <= 1'b0;
      end else if (v3_ff && d2 < best_ff) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         best_ff     <= nadp_pkg::DIST_W'(cfg.cutoff_sq);
         best_idx_ff <= '0;
      end else if (v3_ff && d2 < best_ff) begin
         best_ff     <= d2;
         best_idx_ff <= idx3_ff;
      end
   end

   // accumulator read and saturating update
   assign acc_addr = cmd.acc_use_best ? best_idx_ff : cmd.rd_addr;
   assign acc_cur  = acc_rd_vld_ff ? acc_rd_ff : '0;
   assign sum_wide = {acc_cur.sum[nadp_pkg::ACC_BITS-1], acc_cur.sum}
                   + (nadp_pkg::ACC_BITS+1)'(dens_ff);

   always_comb begin
      acc_new = acc_cur;
      if (sum_wide[nadp_pkg::ACC_BITS] != sum_wide[nadp_pkg::ACC_BITS-1])
         acc_new.sum = sum_wide[nadp_pkg::ACC_BITS]
                     ? {1'b1, {(nadp_pkg::ACC_BITS-1){1'b0}}}
                     : {1'b0, {(nadp_pkg::ACC_BITS-1){1'b1}}};
      else
         acc_new.sum = sum_wide[nadp_pkg::ACC_BITS-1:0];
      if (acc_cur.cnt != nadp_pkg::CNT_MAX)
         acc_new.cnt = acc_cur.cnt + nadp_pkg::CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_rd) begin
         acc_addr_ff   <= acc_addr;
         acc_rd_ff     <= acc_mem[acc_addr];
         acc_rd_vld_ff <= acc_vld_ff[acc_addr];
      end
      if (cmd.acc_wr) acc_mem[acc_addr_ff] <= acc_new;
   end

   // shared 32x32 multiplier, low and high halves on separate cycles
   assign mul_a = cmd.mul_hi ? 32'(mag_ff[nadp_pkg::MAG_W-1:32]) : mag_ff[31:0];
   assign mul_b = cmd.mul_step ? nadp_pkg::SQRT2_Q30 : cfg.voxel_volume;
   assign prod  = mul_a * mul_b;

   // recombine with rounding and the magnitude cap
   always_comb begin
      if (cmd.mul_step) begin
         rnd = {1'b0, p_ff} + (65'd1 << 29);
         rsh = 64'(rnd >> 30);
         qsh = q_ff << 2;
         lim = nadp_pkg::MID_CAP >> 2;
      end else begin
         rnd = {1'b0, p_ff} + (65'd1 << 23);
         rsh = 64'(rnd >> 24);
         qsh = q_ff << 8;
         lim = nadp_pkg::MID_CAP >> 8;
      end
      tsum = qsh + rsh;
      if (q_ff > lim || tsum > nadp_pkg::MID_CAP) tcap = nadp_pkg::MID_CAP;
      else                                        tcap = tsum;
   end

   always_ff @(posedge clock) begin
      if (cmd.proj_init) begin
         neg_ff     <= acc_cur.sum[nadp_pkg::ACC_BITS-1];
         mag_ff     <= acc_cur.sum[nadp_pkg::ACC_BITS-1]
                     ? nadp_pkg::MAG_W'(-{{(nadp_pkg::MAG_W-nadp_pkg::ACC_BITS)
                                           {acc_cur.sum[nadp_pkg::ACC_BITS-1]}},
                                          acc_cur.sum})
                     : nadp_pkg::MAG_W'(acc_cur.sum);
      end else if (cmd.mul_comb) begin
         mag_ff <= tcap[nadp_pkg::MAG_W-1:0];
      end
      if (cmd.mul_en && !cmd.mul_hi) p_ff <= prod;
      if (cmd.mul_en && cmd.mul_hi)  q_ff <= prod;
   end

   // result count of a sample or a total
   always_ff @(posedge clock) begin
      if (cmd.acc_wr)    res_cnt_ff <= acc_new.cnt;
      if (cmd.proj_init) res_cnt_ff <= acc_cur.cnt;
   end

   // sign, charge subtraction and output saturation
   always_comb begin
      sval = neg_ff ? -53'(mag_ff) : 53'(mag_ff);
      vfin = cfg.density_mode ? sval : sval - 53'({atom_rd_ff.q, 20'd0});
      if (vfin > 53'sd140737488355327)       vsat = {1'b0, {(nadp_pkg::OUT_W-1){1'b1}}};
      else if (vfin < -53'sd140737488355328) vsat = {1'b1, {(nadp_pkg::OUT_W-1){1'b0}}};
      else                                   vsat = vfin[nadp_pkg::OUT_W-1:0];
   end

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_sample || cmd.out_total) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_sample) begin
         rsp_ff.result_kind      <= nadp_pkg::RES_SAMPLE;
         rsp_ff.atom_index       <= hit_ff ? 6'(best_idx_ff) : 6'd0;
         rsp_ff.found            <= hit_ff;
         rsp_ff.projected_charge <= '0;
         rsp_ff.element_count    <= hit_ff ? res_cnt_ff : '0;
         rsp_ff.last             <= 1'b0;
      end else if (cmd.out_total) begin
         rsp_ff.result_kind      <= nadp_pkg::RES_TOTAL;
         rsp_ff.atom_index       <= 6'(acc_addr_ff);
         rsp_ff.found            <= 1'b0;
         rsp_ff.projected_charge <= vsat;
         rsp_ff.element_count    <= res_cnt_ff;
         rsp_ff.last             <= cmd.out_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign status.atoms_loaded = loaded_ff;
   assign status.hit          = hit_ff;
   assign status.out_free     = out_free;
   assign status.mode         = cfg.density_mode;

endmodule

@@ rtl/nearest_atom_density_projection_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_atom_density_projection_unit
// Assigns density samples to the nearest loaded atom within a cutoff and
// emits projected per-atom charges on a finish item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  nadp_pkg::req_type
//  rsp      out        rsp_valid/rsp_stall  nadp_pkg::rsp_type
//  csr      in         psel/penable/pready  64-bit registers at 0, 8, 16
//
//  load: accepted while idle. sample: the single distance pipeline takes
//  one atom per cycle, then a three-stage drain; no accumulator update when
//  no atom is in range. finish: per atom a read, a projection step (two in
//  transition mode) and emission, on the shared 32x32 multiplier doing two
//  partial products per step.
//  synchronous reset clears control state and accumulator valid bits at once.
//  one item in flight; input stalls until its results are in the output
//  register, and a result waits there under rsp_stall.
// ----------------------------------------------------------------------------
module nearest_atom_density_projection_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  nadp_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output nadp_pkg::rsp_type   rsp_payload,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [63:0]         pwdata,
   output logic [63:0]         prdata,
   output logic                pready
);

   nadp_pkg::cfg_type    cfg;
   nadp_pkg::cmd_type    cmd;
   nadp_pkg::status_type status;

   // configuration registers
   nadp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer
   nadp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   nadp_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/nadp_checker.sv @@
// ----------------------------------------------------------------------------
// nadp_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "nearest_atom_density_projection_unit_defines.svh"

module nadp_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input nadp_pkg::rsp_type   rsp_payload
);

   // a stalled result holds
   `NADP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // sample results carry no total and never end a finish run
   `NADP_ASSERT_NOW(a_sample_clean, clock, reset, rsp_valid && rsp_payload.result_kind == nadp_pkg::RES_SAMPLE, rsp_payload.projected_charge == '0 && !rsp_payload.last)

   // a dropped sample reports atom zero with no count
   `NADP_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && rsp_payload.result_kind == nadp_pkg::RES_SAMPLE && !rsp_payload.found, rsp_payload.atom_index == 6'd0 && rsp_payload.element_count == '0)

   // totals never set found
   `NADP_ASSERT_NOW(a_total_found, clock, reset, rsp_valid && rsp_payload.result_kind == nadp_pkg::RES_TOTAL, !rsp_payload.found)

endmodule

bind nearest_atom_density_projection_unit nadp_checker u_nadp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

@@ tb/tb_nearest_atom_density_projection_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_atom_density_projection_unit
// Loads atom tables, streams density samples and finish transactions through
// the unit under several register settings. A local model of the nearest-atom
// search and of the charge projection predicts each result; results are
// checked field by field in order, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_nearest_atom_density_projection_unit;

   localparam int  CLK_PERIOD  = 12;
   localparam int  DRAIN_WAIT  = 120;
   localparam int  CYCLE_LIMIT = 1000000;
   localparam longint ACC_HI   = (64'sd1 <<< 47) - 1;
   localparam longint ACC_LO   = -(64'sd1 <<< 47);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   nadp_pkg::req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   nadp_pkg::rsp_type rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   nearest_atom_density_projection_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock
   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // model state: register copies, atom table, accumulators
   logic                       mode_q;
   logic [nadp_pkg::VOL_W-1:0] volume_q;
   logic [nadp_pkg::CUT_W-1:0] cutoff_q;
   longint                     atom_x [nadp_pkg::MAX_ATOMS];
   longint                     atom_y [nadp_pkg::MAX_ATOMS];
   longint                     atom_z [nadp_pkg::MAX_ATOMS];
   logic [nadp_pkg::NUC_W-1:0] atom_q [nadp_pkg::MAX_ATOMS];
   longint                     dens_acc [nadp_pkg::MAX_ATOMS];
   logic [nadp_pkg::CNT_W-1:0] hit_count [nadp_pkg::MAX_ATOMS];
   int                         atoms_in_table;

   nadp_pkg::req_type pending_items[$];
   nadp_pkg::rsp_type expected_rsp[$];
   int      error_count = 0;

   function automatic void clear_atoms();
      for (int i = 0; i < nadp_pkg::MAX_ATOMS; i++) begin
         dens_acc[i]  = 0;
         hit_count[i] = '0;
      end
      atoms_in_table = 0;
   endfunction

   // round(a * b / 2^sh) on magnitudes, capped at the intermediate limit
   function automatic logic [63:0] scale_round(logic [63:0] a, logic [31:0] b, int sh);
      logic [127:0] p;
      p = {64'b0, a} * {96'b0, b};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      return (p > {64'b0, nadp_pkg::MID_CAP}) ? nadp_pkg::MID_CAP : p[63:0];
   endfunction

   function automatic logic [nadp_pkg::OUT_W-1:0] atom_total(int i);
      longint      s;
      longint      v;
      logic [63:0] mag;
      bit          neg;
      s   = dens_acc[i];
      neg = (s < 0);
      mag = neg ? -s : s;
      mag = scale_round(mag, volume_q, 24);
      if (mode_q) mag = scale_round(mag, nadp_pkg::SQRT2_Q30, 30);
      v = neg ? -longint'(mag) : longint'(mag);
      if (!mode_q) v = v - (longint'(atom_q[i]) <<< 20);
      if (v > ACC_HI) v = ACC_HI;
      if (v < ACC_LO) v = ACC_LO;
      return v[nadp_pkg::OUT_W-1:0];
   endfunction

   // nearest-atom search and finish emission for one accepted transaction
   function automatic void predict_results(nadp_pkg::req_type it);
      longint  px, py, pz, dx, dy, dz, d2, best, d;
      int      idx;
      bit      hit;
      nadp_pkg::rsp_type r;
      px = longint'(it.pos_x);
      py = longint'(it.pos_y);
      pz = longint'(it.pos_z);
      case (it.kind)
         nadp_pkg::KIND_LOAD: begin
            if (atoms_in_table < nadp_pkg::MAX_ATOMS) begin
               atom_x[atoms_in_table] = px;
               atom_y[atoms_in_table] = py;
               atom_z[atoms_in_table] = pz;
               atom_q[atoms_in_table] = it.nuclear_charge;
               atoms_in_table++;
            end
         end
         nadp_pkg::KIND_SAMPLE: begin
            best = longint'({16'b0, cutoff_q});
            hit  = 1'b0;
            idx  = 0;
            for (int i = 0; i < atoms_in_table; i++) begin
               dx = atom_x[i] - px;
               dy = atom_y[i] - py;
               dz = atom_z[i] - pz;
               d2 = dx * dx + dy * dy + dz * dz;
               if (d2 < best) begin
                  best = d2;
                  idx  = i;
                  hit  = 1'b1;
               end
            end
            r = '0;
            r.result_kind = nadp_pkg::RES_SAMPLE;
            if (hit) begin
               d = longint'(it.density);
               if (d > 0 && dens_acc[idx] > ACC_HI - d) dens_acc[idx] = ACC_HI;
               else if (d < 0 && dens_acc[idx] < ACC_LO - d) dens_acc[idx] = ACC_LO;
               else dens_acc[idx] = dens_acc[idx] + d;
               if (hit_count[idx] != nadp_pkg::CNT_MAX) hit_count[idx]++;
               r.found         = 1'b1;
               r.atom_index    = idx[5:0];
               r.element_count = hit_count[idx];
            end
            expected_rsp.push_back(r);
         end
         nadp_pkg::KIND_FINISH: begin
            for (int i = 0; i < atoms_in_table; i++) begin
               r = '0;
               r.result_kind      = nadp_pkg::RES_TOTAL;
               r.atom_index       = i[5:0];
               r.projected_charge = atom_total(i);
               r.element_count    = hit_count[i];
               r.last             = (i + 1 == atoms_in_table);
               expected_rsp.push_back(r);
            end
            clear_atoms();
         end
         default: ;
      endcase
   endfunction

   // driver: bursts of transactions separated by random gaps
   int burst_left = 1;
   int gap_left   = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_results(req_payload);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_payload <= pending_items.pop_front();
               req_valid   <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, switching among four styles at random
   int stall_phase = 0;
   int stall_style = 0;
   always @(posedge clock) begin
      stall_phase++;
      if (stall_phase % 50 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_phase % 4 != 0);
      endcase
   end

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
         error_count++;
      end
   endtask

   // monitor: compare each result transaction with the oldest expectation
   nadp_pkg::rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h",
                     $realtime, rsp_payload);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("result_kind", rsp_payload.result_kind, want.result_kind);
            check_field("atom_index", rsp_payload.atom_index, want.atom_index);
            check_field("found", rsp_payload.found, want.found);
            check_field("projected_charge", rsp_payload.projected_charge,
                        want.projected_charge);
            check_field("element_count", rsp_payload.element_count, want.element_count);
            check_field("last", rsp_payload.last, want.last);
         end
      end
   end

   // run limit
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         nadp_pkg::REG_MODE:   mode_q   = value[0];
         nadp_pkg::REG_VOLUME: volume_q = value[nadp_pkg::VOL_W-1:0];
         default:              cutoff_q = value[nadp_pkg::CUT_W-1:0];
      endcase
   endtask

   task automatic set_registers(logic m, logic [nadp_pkg::VOL_W-1:0] vol,
                                logic [nadp_pkg::CUT_W-1:0] cut);
      csr_write(nadp_pkg::REG_MODE, {63'b0, m});
      csr_write(nadp_pkg::REG_VOLUME, {32'b0, vol});
      csr_write(nadp_pkg::REG_CUTOFF, {16'b0, cut});
   endtask

   // wait until every expected result has arrived and the unit has settled
   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic void push_item(logic [1:0] k, int x, int y, int z,
                                     logic [31:0] dens, logic [15:0] q);
      nadp_pkg::req_type it;
      it.kind           = k;
      it.pos_x          = x[23:0];
      it.pos_y          = y[23:0];
      it.pos_z          = z[23:0];
      it.density        = dens;
      it.nuclear_charge = q;
      pending_items.push_back(it);
   endfunction

   function automatic logic [31:0] rand_density();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h1fffffff);
         default: return $urandom;
      endcase
   endfunction

   // one molecule: a few atoms near a center, samples around them, then finish
   task automatic run_molecule(int n_atoms, int n_samples, ref int items_sent);
      int cx, cy, cz, sel, spread;
      int ax [nadp_pkg::MAX_ATOMS + 2];
      int ay [nadp_pkg::MAX_ATOMS + 2];
      int az [nadp_pkg::MAX_ATOMS + 2];
      cx = int'($urandom_range(0, 8388608)) - 4194304;
      cy = int'($urandom_range(0, 8388608)) - 4194304;
      cz = int'($urandom_range(0, 8388608)) - 4194304;
      for (int i = 0; i < n_atoms; i++) begin
         ax[i] = cx + int'($urandom_range(0, 65536)) - 32768;
         ay[i] = cy + int'($urandom_range(0, 65536)) - 32768;
         az[i] = cz + int'($urandom_range(0, 65536)) - 32768;
         push_item(nadp_pkg::KIND_LOAD, ax[i], ay[i], az[i], $urandom, 16'($urandom));
      end
      for (int i = 0; i < n_samples; i++) begin
         case ($urandom_range(0, 19))
            0:  push_item(nadp_pkg::KIND_SAMPLE, $urandom, $urandom, $urandom, $urandom,
                          16'($urandom));
            1:  push_item(2'd3, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
            default: begin
               sel    = $urandom_range(0, (n_atoms > nadp_pkg::MAX_ATOMS
                                           ? nadp_pkg::MAX_ATOMS : n_atoms) - 1);
               spread = ($urandom_range(0, 3) == 0) ? 4096 : 65536;
               push_item(nadp_pkg::KIND_SAMPLE,
                         ax[sel] + int'($urandom_range(0, spread)) - spread / 2,
                         ay[sel] + int'($urandom_range(0, spread)) - spread / 2,
                         az[sel] + int'($urandom_range(0, spread)) - spread / 2,
                         rand_density(), 16'($urandom));
            end
         endcase
         // occasionally let every result come back before going on
         if (i == n_samples / 2 && $urandom_range(0, 3) == 0) drain();
      end
      push_item(nadp_pkg::KIND_FINISH, $urandom, $urandom, $urandom, $urandom,
                16'($urandom));
      items_sent += n_atoms + n_samples + 1;
   endtask

   // stimulus
   initial begin
      int sent;
      mode_q   = 1'b0;
      volume_q = nadp_pkg::VOLUME_RST;
      cutoff_q = nadp_pkg::CUTOFF_RST;
      for (int i = 0; i < nadp_pkg::MAX_ATOMS; i++) begin
         atom_x[i] = 0; atom_y[i] = 0; atom_z[i] = 0; atom_q[i] = '0;
      end
      clear_atoms();
      sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty finish, ignored kind, extreme atoms, ties, cutoff edge
      push_item(nadp_pkg::KIND_FINISH, 0, 0, 0, 32'h0, 16'h0);
      push_item(2'd3, -1, -1, -1, 32'hffffffff, 16'hffff);
      push_item(nadp_pkg::KIND_LOAD, 0, 0, 0, 32'h0, 16'h0100);
      push_item(nadp_pkg::KIND_LOAD, 8192, 0, 0, 32'h0, 16'hffff);
      push_item(nadp_pkg::KIND_LOAD, 8388607, 8388607, 8388607, 32'h7fffffff, 16'h0000);
      push_item(nadp_pkg::KIND_LOAD, -8388608, -8388608, -8388608, 32'h0, 16'h1234);
      push_item(nadp_pkg::KIND_SAMPLE, 4096, 0, 0, 32'h10000000, 16'h0);
      push_item(nadp_pkg::KIND_SAMPLE, 0, 0, 0, 32'h7fffffff, 16'h0);
      push_item(nadp_pkg::KIND_SAMPLE, 8192, 0, 0, 32'h80000000, 16'h0);
      push_item(nadp_pkg::KIND_SAMPLE, 8388607, 8388607, 8388607, 32'hffffffff, 16'h0);
      push_item(nadp_pkg::KIND_SAMPLE, -8388608, -8388608, -8388608, 32'h00000001,
                16'hffff);
      push_item(nadp_pkg::KIND_SAMPLE, 0, -40960, 0, 32'h20000000, 16'h0);
      push_item(nadp_pkg::KIND_SAMPLE, 0, -40959, 0, 32'h20000000, 16'h0);
      push_item(nadp_pkg::KIND_SAMPLE, 0, 4194304, 0, 32'h20000000, 16'h0);
      push_item(nadp_pkg::KIND_FINISH, 0, 0, 0, 32'h0, 16'h0);
      drain();

      // transition mode, largest volume and cutoff
      set_registers(1'b1, 32'hffffffff, 48'hffffffffffff);
      push_item(nadp_pkg::KIND_LOAD, 0, 0, 0, 32'h0, 16'h0800);
      push_item(nadp_pkg::KIND_LOAD, 8388607, 8388607, 8388607, 32'h0, 16'hffff);
      push_item(nadp_pkg::KIND_SAMPLE, -8388608, -8388608, -8388608, 32'h7fffffff,
                16'h0);
      push_item(nadp_pkg::KIND_SAMPLE, 8388607, 8388607, 8388607, 32'h80000000, 16'h0);
      push_item(nadp_pkg::KIND_SAMPLE, 100, 100, 100, 32'h7fffffff, 16'h0);
      push_item(nadp_pkg::KIND_FINISH, 0, 0, 0, 32'h0, 16'h0);
      drain();

      // full table: the loads beyond capacity are dropped
      set_registers(1'b0, nadp_pkg::VOLUME_RST, nadp_pkg::CUTOFF_RST);
      run_molecule(nadp_pkg::MAX_ATOMS + 2, 12, sent);
      drain();

      // random molecules under changing register settings
      while (sent < 260) begin
         case ($urandom_range(0, 5))
            0: set_registers(1'b0, '0, '0);
            1: set_registers(1'b1, 32'hffffffff, 48'hffffffffffff);
            2: set_registers(1'b0, nadp_pkg::VOLUME_RST, nadp_pkg::CUTOFF_RST);
            3: set_registers(1'b1, nadp_pkg::VOLUME_RST, nadp_pkg::CUTOFF_RST);
            default: set_registers(1'($urandom), 32'($urandom),
                                   {14'($urandom_range(0, 3)), 2'b00, 32'($urandom)});
         endcase
         repeat ($urandom_range(1, 3)) run_molecule($urandom_range(1, 8),
                                                   $urandom_range(4, 20), sent);
         drain();
      end

      drain();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
